// ===== src/bcs_pkg.sv =====
// bcs_pkg: types, widths, codes and reset values for the battery charge supervisor
// no dependencies; imported by every other file of the block
`default_nettype none

package bcs_pkg;

   // field widths
   localparam int unsigned VOLT_W     = 20;
   localparam int unsigned CUR_W      = 21;
   localparam int unsigned TEMP_W     = 16;
   localparam int unsigned FAULT_W    = 32;
   localparam int unsigned CODE_W     = 4;
   localparam int unsigned PARAM_W    = 21;
   localparam int unsigned LIMIT_W    = 20;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;

   // register reset values
   localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST       = 16'sd960;
   localparam logic [LIMIT_W-1:0]       MAX_CURRENT_RST    = 20'd200000;
   localparam logic [LIMIT_W-1:0]       MAX_VOLTAGE_RST    = 20'd450000;
   localparam logic [LIMIT_W-1:0]       MIN_VOLTAGE_RST    = 20'd250000;
   localparam logic [LIMIT_W-1:0]       NORMAL_CURRENT_RST = 20'd16000;
   localparam logic [LIMIT_W-1:0]       NORMAL_VOLTAGE_RST = 20'd420000;
   localparam logic [LIMIT_W-1:0]       FAST_CURRENT_RST   = 20'd32000;
   localparam logic [LIMIT_W-1:0]       FAST_VOLTAGE_RST   = 20'd420000;

   // internal fault bit positions
   localparam int unsigned FLT_OVER_TEMP  = 0;
   localparam int unsigned FLT_OVER_CUR   = 1;
   localparam int unsigned FLT_OVER_VOLT  = 2;
   localparam int unsigned FLT_UNDER_VOLT = 3;
   localparam int unsigned FLT_UNKNOWN    = 4;

   // item kind
   localparam logic KIND_SENSOR  = 1'b0;
   localparam logic KIND_COMMAND = 1'b1;

   typedef enum logic [CODE_W-1:0] {
      CMD_NOOP        = 4'd0,
      CMD_START       = 4'd1,
      CMD_STOP        = 4'd2,
      CMD_RESET       = 4'd3,
      CMD_NORMAL      = 4'd4,
      CMD_FAST        = 4'd5,
      CMD_SET_CURRENT = 4'd6,
      CMD_SET_VOLTAGE = 4'd7
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_TEMP       = 3'd0,
      CSR_MAX_CURRENT    = 3'd1,
      CSR_MAX_VOLTAGE    = 3'd2,
      CSR_MIN_VOLTAGE    = 3'd3,
      CSR_NORMAL_CURRENT = 3'd4,
      CSR_NORMAL_VOLTAGE = 3'd5,
      CSR_FAST_CURRENT   = 3'd6,
      CSR_FAST_VOLTAGE   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CHG_IDLE     = 2'd0,
      CHG_CHARGING = 2'd1,
      CHG_FAULT    = 2'd2
   } chg_state_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] max_temp;
      logic [LIMIT_W-1:0]       max_current;
      logic [LIMIT_W-1:0]       max_voltage;
      logic [LIMIT_W-1:0]       min_voltage;
      logic [LIMIT_W-1:0]       normal_current_limit;
      logic [LIMIT_W-1:0]       normal_voltage_limit;
      logic [LIMIT_W-1:0]       fast_current_limit;
      logic [LIMIT_W-1:0]       fast_voltage_limit;
   } cfg_type;

   typedef struct packed {
      logic               charge_requested;
      logic               fast_selected;
      logic [LIMIT_W-1:0] active_current_limit;
      logic [LIMIT_W-1:0] active_voltage_limit;
      logic               unknown_command_seen;
   } sup_state_type;

   typedef struct packed {
      logic                      mode;
      logic [VOLT_W-1:0]         battery_voltage;
      logic signed [CUR_W-1:0]   charge_current;
      logic signed [TEMP_W-1:0]  battery_temp;
      logic [FAULT_W-1:0]        sensor_faults;
      logic [CODE_W-1:0]         command_code;
      logic signed [PARAM_W-1:0] cmd_arg;
   } req_item_type;

   typedef struct packed {
      logic               charge_en;
      logic [LIMIT_W-1:0] current_limit_out;
      logic [LIMIT_W-1:0] voltage_limit_out;
      logic               fast_active;
      logic [1:0]         chg_status;
      logic [FAULT_W-1:0] fault_word;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== src/bcs_if.sv =====
// request and response channel interfaces of the battery charge supervisor
// depends on bcs_pkg for field widths
`default_nettype none

interface bcs_req_if import bcs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [VOLT_W-1:0]         battery_voltage;
   logic signed [CUR_W-1:0]   charge_current;
   logic signed [TEMP_W-1:0]  battery_temp;
   logic [FAULT_W-1:0]        sensor_faults;
   logic [CODE_W-1:0]         command_code;
   logic signed [PARAM_W-1:0] cmd_arg;

   modport source (
      output valid, mode, battery_voltage, charge_current, battery_temp,
             sensor_faults, command_code, cmd_arg,
      input  ready
   );
   modport sink (
      input  valid, mode, battery_voltage, charge_current, battery_temp,
             sensor_faults, command_code, cmd_arg,
      output ready
   );
endinterface

interface bcs_rsp_if import bcs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               charge_en;
   logic [LIMIT_W-1:0] current_limit_out;
   logic [LIMIT_W-1:0] voltage_limit_out;
   logic               fast_active;
   logic [1:0]         chg_status;
   logic [FAULT_W-1:0] fault_word;

   modport source (
      output valid, charge_en, current_limit_out, voltage_limit_out,
             fast_active, chg_status, fault_word,
      input  ready
   );
   modport sink (
      input  valid, charge_en, current_limit_out, voltage_limit_out,
             fast_active, chg_status, fault_word,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/bcs_csr.sv =====
// bcs_csr: threshold and mode limit registers, written through the plain csr port
// depends on bcs_pkg
`default_nettype none

module bcs_csr import bcs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_TEMP:       cfg_in.max_temp = csr_wr_data[TEMP_W-1:0];
            CSR_MAX_CURRENT:    cfg_in.max_current = csr_wr_data[LIMIT_W-1:0];
            CSR_MAX_VOLTAGE:    cfg_in.max_voltage = csr_wr_data[LIMIT_W-1:0];
            CSR_MIN_VOLTAGE:    cfg_in.min_voltage = csr_wr_data[LIMIT_W-1:0];
            CSR_NORMAL_CURRENT: cfg_in.normal_current_limit = csr_wr_data[LIMIT_W-1:0];
            CSR_NORMAL_VOLTAGE: cfg_in.normal_voltage_limit = csr_wr_data[LIMIT_W-1:0];
            CSR_FAST_CURRENT:   cfg_in.fast_current_limit = csr_wr_data[LIMIT_W-1:0];
            CSR_FAST_VOLTAGE:   cfg_in.fast_voltage_limit = csr_wr_data[LIMIT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_temp             <= MAX_TEMP_RST;
         cfg_ff.max_current          <= MAX_CURRENT_RST;
         cfg_ff.max_voltage          <= MAX_VOLTAGE_RST;
         cfg_ff.min_voltage          <= MIN_VOLTAGE_RST;
         cfg_ff.normal_current_limit <= NORMAL_CURRENT_RST;
         cfg_ff.normal_voltage_limit <= NORMAL_VOLTAGE_RST;
         cfg_ff.fast_current_limit   <= FAST_CURRENT_RST;
         cfg_ff.fast_voltage_limit   <= FAST_VOLTAGE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/bcs_ctrl.sv =====
// bcs_ctrl: supervisor state (request, mode, active limits, sticky fault) updated by commands
// depends on bcs_pkg
`default_nettype none

module bcs_ctrl import bcs_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      cmd_fire,
   input  wire logic [CODE_W-1:0]         cmd_code,
   input  wire logic signed [PARAM_W-1:0] cmd_param,
   input  wire cfg_type                   cfg,
   output sup_state_type                  state
);

   sup_state_type state_ff;
   sup_state_type state_in;
   logic          param_positive;

   // a set command applies only a strictly positive parameter
   assign param_positive = !cmd_param[PARAM_W-1] && (cmd_param != '0);

   // command decode
   always_comb begin
      state_in = state_ff;
      if (cmd_fire) begin
         case (cmd_type'(cmd_code))
            CMD_NOOP:  state_in = state_ff;
            CMD_START: state_in.charge_requested = 1'b1;
            CMD_STOP:  state_in.charge_requested = 1'b0;
            CMD_RESET: begin
               state_in.charge_requested     = 1'b0;
               state_in.unknown_command_seen = 1'b0;
               state_in.fast_selected        = 1'b0;
               state_in.active_current_limit = cfg.normal_current_limit;
               state_in.active_voltage_limit = cfg.normal_voltage_limit;
            end
            CMD_NORMAL: begin
               state_in.fast_selected        = 1'b0;
               state_in.active_current_limit = cfg.normal_current_limit;
               state_in.active_voltage_limit = cfg.normal_voltage_limit;
            end
            CMD_FAST: begin
               state_in.fast_selected        = 1'b1;
               state_in.active_current_limit = cfg.fast_current_limit;
               state_in.active_voltage_limit = cfg.fast_voltage_limit;
            end
            CMD_SET_CURRENT: begin
               if (param_positive) begin
                  state_in.active_current_limit = cmd_param[LIMIT_W-1:0];
               end
            end
            CMD_SET_VOLTAGE: begin
               if (param_positive) begin
                  state_in.active_voltage_limit = cmd_param[LIMIT_W-1:0];
               end
            end
            default: state_in.unknown_command_seen = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.charge_requested     <= 1'b0;
         state_ff.fast_selected        <= 1'b0;
         state_ff.active_current_limit <= NORMAL_CURRENT_RST;
         state_ff.active_voltage_limit <= NORMAL_VOLTAGE_RST;
         state_ff.unknown_command_seen <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

`default_nettype wire

// ===== src/bcs_check.sv =====
// bcs_check: threshold checks on a sensor frame and forming of the result transaction
// depends on bcs_pkg
`default_nettype none

module bcs_check import bcs_pkg::*; (
   input  wire req_item_type  item,
   input  wire cfg_type       cfg,
   input  wire sup_state_type state,
   output rsp_item_type       result
);

   logic [CUR_W-1:0]   cur_mag;
   logic [FAULT_W-1:0] faults;
   logic               enable;

   // magnitude at full width: the most negative current maps to 2^20
   assign cur_mag = item.charge_current[CUR_W-1] ? (~item.charge_current + 1'b1)
                                                 : item.charge_current;

   // fault word: sensor flags plus internal bits
   always_comb begin
      faults = item.sensor_faults;
      if (item.battery_temp > cfg.max_temp)             faults[FLT_OVER_TEMP]  = 1'b1;
      if (cur_mag > {1'b0, cfg.max_current})            faults[FLT_OVER_CUR]   = 1'b1;
      if (item.battery_voltage > cfg.max_voltage)       faults[FLT_OVER_VOLT]  = 1'b1;
      if (item.battery_voltage < cfg.min_voltage)       faults[FLT_UNDER_VOLT] = 1'b1;
      if (state.unknown_command_seen)                   faults[FLT_UNKNOWN]    = 1'b1;
   end

   assign enable = state.charge_requested && (faults == '0);

   // result fields
   always_comb begin
      result.charge_en         = enable;
      result.current_limit_out = enable ? state.active_current_limit : '0;
      result.voltage_limit_out = enable ? state.active_voltage_limit : '0;
      result.fast_active       = state.fast_selected;
      if (faults != '0) begin
         result.chg_status = CHG_FAULT;
      end else if (enable) begin
         result.chg_status = CHG_CHARGING;
      end else begin
         result.chg_status = CHG_IDLE;
      end
      result.fault_word = faults;
   end

endmodule

`default_nettype wire

// ===== src/battery_charge_supervisor_top.sv =====
// battery_charge_supervisor_top: input register, command/state logic, frame checks, result register
// depends on bcs_pkg, bcs_if, bcs_csr, bcs_ctrl, bcs_check
// a sensor frame's result is registered from the input register into the result register
// throughput: one transaction per cycle unless the input stalls; commands update state and give no result
// input stalls only when a frame waits behind an untaken result
// reset (synchronous): thresholds and limits to defaults, request/mode/sticky fault cleared
`default_nettype none

module battery_charge_supervisor_top import bcs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bcs_req_if.sink                    req_chan,
   bcs_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type       cfg;
   sup_state_type state;
   rsp_item_type  result;

   logic          req_vld_ff, req_vld_in;
   req_item_type  req_item_ff, req_item_in;
   logic          rsp_vld_ff, rsp_vld_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   logic          req_accept;
   logic          out_free;
   logic          advance;
   logic          cmd_fire;

   // configuration registers
   bcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // supervisor state
   bcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_fire  (cmd_fire),
      .cmd_code  (req_item_ff.command_code),
      .cmd_param (req_item_ff.cmd_arg),
      .cfg       (cfg),
      .state     (state)
   );

   // frame checks
   bcs_check u_check (
      .item   (req_item_ff),
      .cfg    (cfg),
      .state  (state),
      .result (result)
   );

   // handshake control: a command never needs the result slot
   assign out_free   = !rsp_vld_ff || rsp_chan.ready;
   assign advance    = req_vld_ff && ((req_item_ff.mode == KIND_COMMAND) || out_free);
   assign cmd_fire   = advance && (req_item_ff.mode == KIND_COMMAND);
   assign req_chan.ready = !req_vld_ff || advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   // input register
   always_comb begin
      req_item_in = req_item_ff;
      req_vld_in  = req_vld_ff && !advance;
      if (req_accept) begin
         req_vld_in                  = 1'b1;
         req_item_in.mode            = req_chan.mode;
         req_item_in.battery_voltage = req_chan.battery_voltage;
         req_item_in.charge_current  = req_chan.charge_current;
         req_item_in.battery_temp    = req_chan.battery_temp;
         req_item_in.sensor_faults   = req_chan.sensor_faults;
         req_item_in.command_code    = req_chan.command_code;
         req_item_in.cmd_arg         = req_chan.cmd_arg;
      end
   end

   // result register
   always_comb begin
      rsp_item_in = rsp_item_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      if (advance && (req_item_ff.mode == KIND_SENSOR)) begin
         rsp_vld_in  = 1'b1;
         rsp_item_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   // response outputs
   assign rsp_chan.valid             = rsp_vld_ff;
   assign rsp_chan.charge_en         = rsp_item_ff.charge_en;
   assign rsp_chan.current_limit_out = rsp_item_ff.current_limit_out;
   assign rsp_chan.voltage_limit_out = rsp_item_ff.voltage_limit_out;
   assign rsp_chan.fast_active       = rsp_item_ff.fast_active;
   assign rsp_chan.chg_status        = rsp_item_ff.chg_status;
   assign rsp_chan.fault_word        = rsp_item_ff.fault_word;

endmodule

`default_nettype wire

// ===== verif/battery_charge_supervisor_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for battery_charge_supervisor_top: drives frames, commands and csr
// writes, predicts every frame verdict in a scoreboard class and checks each result transaction
// depends on bcs_pkg, bcs_if and the battery_charge_supervisor_top rtl

module battery_charge_supervisor_top_tb;
   import bcs_pkg::*;

   localparam int LIMIT_MAX        = 2**LIMIT_W - 1;
   localparam int TEMP_MIN         = -(2**(TEMP_W-1));
   localparam int TEMP_MAX         = 2**(TEMP_W-1) - 1;
   localparam int MOST_NEG_CURRENT = -(2**(CUR_W-1));

   // command codes outside the defined set
   localparam logic [CODE_W-1:0] CMD_UNKNOWN_LO = 4'd8;
   localparam logic [CODE_W-1:0] CMD_UNKNOWN_HI = 4'd15;

   // stimulus phases, each with its own register setting
   localparam int unsigned N_PHASES   = 8;
   localparam int unsigned PHASE_LOW  = 2;
   localparam int unsigned PHASE_HIGH = 3;
   localparam int unsigned PHASE_WILD = 5;

   localparam int unsigned LONG_HOLD_CYCLES = 80;
   localparam int unsigned SETTLE_CYCLES    = 4;
   localparam int unsigned DRAIN_LIMIT      = 4000;
   localparam int unsigned REPORT_LIMIT     = 10;

   // supervisor state and register mirror, plus the queue of pending frame verdicts
   class supervisor_scoreboard;
      cfg_type       cfg;
      sup_state_type st;
      rsp_item_type  frame_verdicts[$];
      int unsigned   mismatch_count;

      function new();
         cfg = '{MAX_TEMP_RST, MAX_CURRENT_RST, MAX_VOLTAGE_RST, MIN_VOLTAGE_RST,
                 NORMAL_CURRENT_RST, NORMAL_VOLTAGE_RST, FAST_CURRENT_RST, FAST_VOLTAGE_RST};
         st.charge_requested     = 1'b0;
         st.unknown_command_seen = 1'b0;
         load_normal();
         mismatch_count = 0;
      endfunction

      function void load_normal();
         st.fast_selected        = 1'b0;
         st.active_current_limit = cfg.normal_current_limit;
         st.active_voltage_limit = cfg.normal_voltage_limit;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MAX_TEMP:       cfg.max_temp             = data[TEMP_W-1:0];
            CSR_MAX_CURRENT:    cfg.max_current          = data[LIMIT_W-1:0];
            CSR_MAX_VOLTAGE:    cfg.max_voltage          = data[LIMIT_W-1:0];
            CSR_MIN_VOLTAGE:    cfg.min_voltage          = data[LIMIT_W-1:0];
            CSR_NORMAL_CURRENT: cfg.normal_current_limit = data[LIMIT_W-1:0];
            CSR_NORMAL_VOLTAGE: cfg.normal_voltage_limit = data[LIMIT_W-1:0];
            CSR_FAST_CURRENT:   cfg.fast_current_limit   = data[LIMIT_W-1:0];
            CSR_FAST_VOLTAGE:   cfg.fast_voltage_limit   = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // commands move the state, frames give one verdict
      function void apply_request(req_item_type it);
         rsp_item_type          verdict;
         logic [FAULT_W-1:0]    flags;
         logic signed [CUR_W:0] cur_wide;
         logic [CUR_W:0]        magnitude;
         logic                  en;
         if (it.mode == KIND_COMMAND) begin
            case (it.command_code)
               CMD_NOOP: ;
               CMD_START: st.charge_requested = 1'b1;
               CMD_STOP:  st.charge_requested = 1'b0;
               CMD_RESET: begin
                  st.charge_requested     = 1'b0;
                  st.unknown_command_seen = 1'b0;
                  load_normal();
               end
               CMD_NORMAL: load_normal();
               CMD_FAST: begin
                  st.fast_selected        = 1'b1;
                  st.active_current_limit = cfg.fast_current_limit;
                  st.active_voltage_limit = cfg.fast_voltage_limit;
               end
               CMD_SET_CURRENT: begin
                  if ($signed(it.cmd_arg) > 0)
                     st.active_current_limit = it.cmd_arg[LIMIT_W-1:0];
               end
               CMD_SET_VOLTAGE: begin
                  if ($signed(it.cmd_arg) > 0)
                     st.active_voltage_limit = it.cmd_arg[LIMIT_W-1:0];
               end
               default: st.unknown_command_seen = 1'b1;
            endcase
            return;
         end

         // magnitude at one bit wider so the most negative current stays large
         flags     = it.sensor_faults;
         cur_wide  = $signed(it.charge_current);
         magnitude = cur_wide[CUR_W] ? (~cur_wide + 1'b1) : cur_wide;
         if (st.unknown_command_seen) flags[FLT_UNKNOWN] = 1'b1;
         if ($signed(it.battery_temp) > $signed(cfg.max_temp)) flags[FLT_OVER_TEMP] = 1'b1;
         if (magnitude > cfg.max_current) flags[FLT_OVER_CUR] = 1'b1;
         if (it.battery_voltage > cfg.max_voltage) flags[FLT_OVER_VOLT] = 1'b1;
         if (it.battery_voltage < cfg.min_voltage) flags[FLT_UNDER_VOLT] = 1'b1;

         en = st.charge_requested && (flags == '0);
         verdict.charge_en         = en;
         verdict.current_limit_out = en ? st.active_current_limit : '0;
         verdict.voltage_limit_out = en ? st.active_voltage_limit : '0;
         verdict.fast_active       = st.fast_selected;
         verdict.chg_status        = (flags != '0) ? CHG_FAULT : (en ? CHG_CHARGING : CHG_IDLE);
         verdict.fault_word        = flags;
         frame_verdicts.push_back(verdict);
      endfunction

      function void check_verdict(rsp_item_type got);
         rsp_item_type want;
         if (frame_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: result transaction with no frame pending: faults=%h", $realtime,
                        got.fault_word);
            return;
         end
         want = frame_verdicts.pop_front();
         if (got.charge_en !== want.charge_en ||
             got.current_limit_out !== want.current_limit_out ||
             got.voltage_limit_out !== want.voltage_limit_out ||
             got.fast_active !== want.fast_active ||
             got.chg_status !== want.chg_status ||
             got.fault_word !== want.fault_word) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: verdict mismatch", $realtime);
               $display("  expected en=%0b cur=%0d volt=%0d fast=%0b state=%0d faults=%h",
                        want.charge_en, want.current_limit_out, want.voltage_limit_out,
                        want.fast_active, want.chg_status, want.fault_word);
               $display("  actual   en=%0b cur=%0d volt=%0d fast=%0b state=%0d faults=%h",
                        got.charge_en, got.current_limit_out, got.voltage_limit_out,
                        got.fast_active, got.chg_status, got.fault_word);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   // idling control shared by the two sides
   bit   req_steady      = 1'b0;
   bit   rsp_steady      = 1'b0;
   bit   start_long_hold = 1'b0;
   logic rsp_hold        = 1'b0;

   supervisor_scoreboard scoreboard;

   bcs_req_if req_chan ();
   bcs_rsp_if rsp_chan ();

   battery_charge_supervisor_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned draw_gap(bit steady);
      return steady ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic req_item_type make_frame(int unsigned volt, int cur, int temp,
                                               logic [FAULT_W-1:0] flags);
      req_item_type it;
      it.mode            = KIND_SENSOR;
      it.battery_voltage = VOLT_W'(volt);
      it.charge_current  = CUR_W'(cur);
      it.battery_temp    = TEMP_W'(temp);
      it.sensor_faults   = flags;
      it.command_code    = CODE_W'($urandom);
      it.cmd_arg         = PARAM_W'($urandom);
      return it;
   endfunction

   function automatic req_item_type make_command(logic [CODE_W-1:0] code, int param);
      req_item_type it;
      it.mode            = KIND_COMMAND;
      it.battery_voltage = VOLT_W'($urandom);
      it.charge_current  = CUR_W'($urandom);
      it.battery_temp    = TEMP_W'($urandom);
      it.sensor_faults   = $urandom;
      it.command_code    = code;
      it.cmd_arg         = PARAM_W'(param);
      return it;
   endfunction

   // frames mostly sit around the thresholds in force, with some raw noise
   function automatic req_item_type random_frame();
      int unsigned        lo, hi, mc, volt, mag, sel;
      int                 mt, temp, cur;
      logic [FAULT_W-1:0] flags;
      lo  = scoreboard.cfg.min_voltage;
      hi  = scoreboard.cfg.max_voltage;
      sel = $urandom_range(0, 9);
      if (sel < 6) volt = $urandom_range(hi, lo);
      else if (sel < 8) volt = ($urandom_range(0, 1) ? hi : lo) + $urandom_range(0, 2) - 1;
      else volt = $urandom;

      mc  = scoreboard.cfg.max_current;
      sel = $urandom_range(0, 19);
      if (sel < 12) mag = $urandom_range(mc, 0);
      else if (sel < 16) mag = mc + $urandom_range(0, 1);
      else mag = $urandom;
      cur = (sel == 19) ? MOST_NEG_CURRENT : ($urandom_range(0, 1) ? -int'(mag) : int'(mag));

      mt  = $signed(scoreboard.cfg.max_temp);
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         temp = mt - int'($urandom_range(0, 1500));
         if (temp < TEMP_MIN) temp = TEMP_MIN;
      end else if (sel < 8) begin
         temp = mt + int'($urandom_range(0, 1));
      end else begin
         temp = $urandom;
      end

      sel = $urandom_range(0, 19);
      if (sel < 14) flags = '0;
      else if (sel < 17) flags = 32'd1 << $urandom_range(0, FAULT_W - 1);
      else flags = $urandom;
      return make_frame(volt, cur, temp, flags);
   endfunction

   // commands lean towards start and limit changes, unknown codes stay rare
   function automatic req_item_type random_command();
      int unsigned       pick, psel;
      int                param;
      logic [CODE_W-1:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 30) code = CMD_START;
      else if (pick < 38) code = CMD_STOP;
      else if (pick < 44) code = CMD_RESET;
      else if (pick < 54) code = CMD_NORMAL;
      else if (pick < 64) code = CMD_FAST;
      else if (pick < 77) code = CMD_SET_CURRENT;
      else if (pick < 90) code = CMD_SET_VOLTAGE;
      else if (pick < 95) code = CMD_NOOP;
      else code = CODE_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
      psel = $urandom_range(0, 9);
      if (psel < 6) param = $urandom_range(1, LIMIT_MAX);
      else if (psel < 8) param = int'($urandom);
      else if (psel < 9) param = 0;
      else param = -int'($urandom_range(1, LIMIT_MAX + 1));
      return make_command(code, param);
   endfunction

   function automatic req_item_type random_item();
      return ($urandom_range(0, 99) < 22) ? random_command() : random_frame();
   endfunction

   function automatic cfg_type phase_config(int unsigned phase);
      cfg_type         c;
      logic [5*32-1:0] noise;
      if (phase == PHASE_LOW) begin
         c          = '0;
         c.max_temp = TEMP_W'(TEMP_MIN);
      end else if (phase == PHASE_HIGH) begin
         c          = '1;
         c.max_temp = TEMP_W'(TEMP_MAX);
      end else if (phase == PHASE_WILD) begin
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
         c     = noise[$bits(cfg_type)-1:0];
      end else begin
         c.max_temp             = TEMP_W'($urandom_range(400, 1400));
         c.max_current          = LIMIT_W'($urandom_range(50000, 400000));
         c.max_voltage          = LIMIT_W'($urandom_range(400000, 520000));
         c.min_voltage          = LIMIT_W'($urandom_range(200000, 320000));
         c.normal_current_limit = LIMIT_W'($urandom);
         c.normal_voltage_limit = LIMIT_W'($urandom);
         c.fast_current_limit   = LIMIT_W'($urandom);
         c.fast_voltage_limit   = LIMIT_W'($urandom);
      end
      return c;
   endfunction

   // one transaction on the request channel; valid stays high when no gap follows
   task automatic send_item(input req_item_type it);
      int unsigned gap;
      gap = draw_gap(req_steady);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.mode            <= it.mode;
      req_chan.battery_voltage <= it.battery_voltage;
      req_chan.charge_current  <= it.charge_current;
      req_chan.battery_temp    <= it.battery_temp;
      req_chan.sensor_faults   <= it.sensor_faults;
      req_chan.command_code    <= it.command_code;
      req_chan.cmd_arg         <= it.cmd_arg;
      do @(posedge clock); while (!req_chan.ready);
      scoreboard.apply_request(it);
   endtask

   // pause until every verdict is in, then let a trailing command settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (scoreboard.frame_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      scoreboard.write_register(idx, data);
   endtask

   task automatic write_config(input cfg_type c);
      put_csr(CSR_MAX_TEMP,       CSR_DATA_W'($signed(c.max_temp)));
      put_csr(CSR_MAX_CURRENT,    c.max_current);
      put_csr(CSR_MAX_VOLTAGE,    c.max_voltage);
      put_csr(CSR_MIN_VOLTAGE,    c.min_voltage);
      put_csr(CSR_NORMAL_CURRENT, c.normal_current_limit);
      put_csr(CSR_NORMAL_VOLTAGE, c.normal_voltage_limit);
      put_csr(CSR_FAST_CURRENT,   c.fast_current_limit);
      put_csr(CSR_FAST_VOLTAGE,   c.fast_voltage_limit);
      csr_wr_en <= 1'b0;
   endtask

   // threshold edges, field extremes and every command at the reset setting
   task automatic run_directed();
      send_item(make_frame(400000, 1000, 400, '0));
      send_item(make_command(CMD_START, 0));
      send_item(make_frame(400000, 1000, 400, '0));
      send_item(make_frame(250000, 1000, 960, '0));
      send_item(make_frame(400000, 1000, 961, '0));
      send_item(make_frame(450000, 200000, 400, '0));
      send_item(make_frame(400000, -200001, 400, '0));
      send_item(make_frame(249999, 1000, 400, '0));
      send_item(make_frame(450001, 1000, 400, '0));
      send_item(make_frame(LIMIT_MAX, LIMIT_MAX, TEMP_MAX, 32'h8000_0000));
      send_item(make_frame(0, MOST_NEG_CURRENT, TEMP_MIN, '1));
      send_item(make_command(CMD_FAST, 0));
      send_item(make_command(CMD_SET_CURRENT, LIMIT_MAX));
      send_item(make_command(CMD_SET_VOLTAGE, MOST_NEG_CURRENT));
      send_item(make_command(CMD_SET_CURRENT, 0));
      send_item(make_command(CMD_SET_VOLTAGE, 1));
      send_item(make_frame(400000, -1000, 400, '0));
      send_item(make_command(CMD_NOOP, 0));
      send_item(make_command(CMD_NORMAL, 0));
      send_item(make_frame(400000, 1000, 400, '0));
      send_item(make_command(CMD_STOP, 0));
      send_item(make_frame(400000, 1000, 400, '0));
      send_item(make_command(CMD_START, 0));
      send_item(make_command(CMD_UNKNOWN_LO, 0));
      send_item(make_frame(400000, 1000, 400, '0));
      send_item(make_command(CMD_UNKNOWN_HI, 0));
      send_item(make_command(CMD_RESET, 0));
      send_item(make_frame(400000, 1000, 400, '0));
   endtask

   // result side: check each transaction, then idle for a drawn number of cycles
   initial begin : result_sink
      int unsigned  wait_left;
      rsp_item_type got;
      wait_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.charge_en         = rsp_chan.charge_en;
            got.current_limit_out = rsp_chan.current_limit_out;
            got.voltage_limit_out = rsp_chan.voltage_limit_out;
            got.fast_active       = rsp_chan.fast_active;
            got.chg_status        = rsp_chan.chg_status;
            got.fault_word        = rsp_chan.fault_word;
            scoreboard.check_verdict(got);
            wait_left = draw_gap(rsp_steady);
         end
         if (reset || rsp_hold) begin
            rsp_chan.ready <= 1'b0;
         end else if (wait_left != 0) begin
            rsp_chan.ready <= 1'b0;
            wait_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   initial begin : long_hold
      wait (start_long_hold);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #2000000;
      $display("battery_charge_supervisor_top verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase, drained;
      scoreboard = new();
      req_chan.valid           <= 1'b0;
      req_chan.mode            <= KIND_SENSOR;
      req_chan.battery_voltage <= '0;
      req_chan.charge_current  <= '0;
      req_chan.battery_temp    <= '0;
      req_chan.sensor_faults   <= '0;
      req_chan.command_code    <= CMD_NOOP;
      req_chan.cmd_arg         <= '0;
      csr_wr_en                <= 1'b0;
      csr_index                <= CSR_MAX_TEMP;
      csr_wr_data              <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (phase = 0; phase < N_PHASES; phase++) begin
         wait_idle();
         write_config(phase_config(phase));
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         if (phase == 0) begin
            req_steady      = 1'b1;
            start_long_hold = 1'b1;
         end
         // each phase picks at random: reload the new limits at once, or keep the old ones
         if ($urandom_range(0, 1) != 0) begin
            send_item(make_command(CMD_RESET, 0));
            send_item(make_command(CMD_START, 0));
         end
         repeat ((phase == 0) ? 200 : 145) send_item(random_item());
      end

      // drain, then wait the settle time to catch stray results
      req_chan.valid <= 1'b0;
      drained = 0;
      while (scoreboard.frame_verdicts.size() != 0 && drained < DRAIN_LIMIT) begin
         @(posedge clock);
         drained++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (scoreboard.frame_verdicts.size() != 0) begin
         $display("%0d frame verdicts never arrived", scoreboard.frame_verdicts.size());
         scoreboard.mismatch_count++;
      end

      if (scoreboard.mismatch_count == 0)
         $display("battery_charge_supervisor_top verification clean");
      else
         $display("battery_charge_supervisor_top verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/bcs_pkg.sv
src/bcs_if.sv
src/bcs_csr.sv
src/bcs_ctrl.sv
src/bcs_check.sv
src/battery_charge_supervisor_top.sv
verif/battery_charge_supervisor_top_tb.sv
